// ----- hw/rtl/ffra_pkg.sv -----
// shared types, codes and constants of the first-fit region allocator
`default_nettype none

package ffra_pkg;

    // heap geometry: one header word per unit, null link is one past the last unit
    localparam int HEAP_UNITS  = 4096;
    localparam int ADDR_W      = $clog2(HEAP_UNITS);
    localparam int SIZE_W      = 13;
    localparam int NUM_REGIONS = 4;
    localparam int CFG_REGIONS = 4;
    localparam logic [SIZE_W-1:0] NIL_LINK = SIZE_W'(HEAP_UNITS);

    // operation codes
    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    // result status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_BASE_ZERO  = 3'd0;
    localparam logic [2:0] CFG_BASE_ONE   = 3'd1;
    localparam logic [2:0] CFG_BASE_TWO   = 3'd2;
    localparam logic [2:0] CFG_BASE_THREE = 3'd3;
    localparam logic [2:0] CFG_SPAN_ZERO  = 3'd4;
    localparam logic [2:0] CFG_SPAN_ONE   = 3'd5;
    localparam logic [2:0] CFG_SPAN_TWO   = 3'd6;
    localparam logic [2:0] CFG_SPAN_THREE = 3'd7;

    // command transfer
    typedef struct packed {
        logic [1:0]  opcode;
        logic [1:0]  region_sel;
        logic [14:0] request_bytes;
        logic [11:0] release_unit;
    } t_cmd;

    // result transfer
    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] data_unit;
        logic [12:0] units_left;
    } t_result;

    // block header held in each heap word
    typedef struct packed {
        logic              used;
        logic [1:0]        region;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] link;
    } t_hdr;

    // heap memory access request
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_hdr              wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_ram_req;

endpackage

`default_nettype wire

// ----- hw/rtl/ffra_heap_ram.sv -----
// heap header memory: one write port, one read port, registered read data
`default_nettype none

module ffra_heap_ram (
    input  wire logic             i_clk,
    input  wire ffra_pkg::t_ram_req i_req,
    output ffra_pkg::t_hdr        o_q
);

    ffra_pkg::t_hdr r_mem [ffra_pkg::HEAP_UNITS];
    ffra_pkg::t_hdr r_q;

    // write and read; read data is registered and appears in the cycle after the read request
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_q <= r_mem[i_req.rd_addr];
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ffra_ctrl.sv -----
// sequencer: list walks, splits and merges over the heap memory, per-region state
`default_nettype none

module ffra_ctrl #(
    parameter int NUM_REGIONS = ffra_pkg::NUM_REGIONS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire ffra_pkg::t_cmd       i_cmd,
    input  wire logic [11:0]          i_base [ffra_pkg::CFG_REGIONS],
    input  wire logic [12:0]          i_span [ffra_pkg::CFG_REGIONS],
    output logic                      o_res_valid,
    output ffra_pkg::t_result         o_result,
    output ffra_pkg::t_ram_req        o_ram_req,
    input  wire ffra_pkg::t_hdr       i_ram_q
);

    localparam int RW = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
    localparam int AW = ffra_pkg::ADDR_W;
    localparam int SW = ffra_pkg::SIZE_W;
    localparam logic [SW-1:0] NIL = ffra_pkg::NIL_LINK;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT_WR,
        S_A_RD, S_A_CHK, S_A_SPL1, S_A_SPL2, S_A_EX1, S_A_EX2,
        S_F_RD, S_F_CHK, S_F_HCHK, S_F_TOP,
        S_W_RD, S_W_CHK, S_W_M1, S_W_M2, S_W_M3, S_W_M4,
        S_I_LNK, S_I_RD, S_I_CHK
    } t_state;

    t_state r_state, n_state;
    logic [1:0]    r_reg, n_reg;
    logic [SW-1:0] r_need, n_need;
    logic [AW-1:0] r_h, n_h;
    logic [SW-1:0] r_blk, n_blk;
    logic [SW-1:0] r_prev, n_prev;
    logic [SW-1:0] r_steps, n_steps;
    logic [SW-1:0] r_aux, n_aux;
    ffra_pkg::t_hdr r_f, n_f;
    ffra_pkg::t_hdr r_b, n_b;
    ffra_pkg::t_hdr r_p, n_p;
    logic [SW-1:0] r_free_head [NUM_REGIONS];
    logic [SW-1:0] n_free_head [NUM_REGIONS];
    logic [SW-1:0] r_left [NUM_REGIONS];
    logic [SW-1:0] n_left [NUM_REGIONS];
    logic [NUM_REGIONS-1:0] r_ready, n_ready;
    logic r_res_valid, n_res_valid;
    ffra_pkg::t_result r_res, n_res;
    ffra_pkg::t_ram_req req;

    logic [RW-1:0] cmd_ri, cur_ri, q_ri;
    logic          cmd_reg_ok, q_reg_ok;
    logic [15:0]   need_sum;
    logic [SW-1:0] need_calc;
    logic [SW-1:0] cur_left, cur_head, q_head, init_size, new_size, split_sum;
    logic [SW:0]   f_end, b_end, g_sum;

    // request decode and per-region lookups
    assign cmd_ri     = i_cmd.region_sel[RW-1:0];
    assign cmd_reg_ok = {1'b0, i_cmd.region_sel} < 3'(NUM_REGIONS);
    assign cur_ri     = r_reg[RW-1:0];
    assign cur_left   = r_left[cur_ri];
    assign cur_head   = r_free_head[cur_ri];
    assign q_ri       = i_ram_q.region[RW-1:0];
    assign q_reg_ok   = {1'b0, i_ram_q.region} < 3'(NUM_REGIONS);
    assign q_head     = r_free_head[q_ri];
    assign need_sum   = {1'b0, i_cmd.request_bytes} + 16'd7;
    assign need_calc  = need_sum[15:3] + 13'd1;
    assign init_size  = (i_span[r_reg] != 13'd0) ? i_span[r_reg] - 13'd1 : 13'd0;
    assign new_size   = i_ram_q.size - r_need;
    assign split_sum  = r_blk + new_size;
    assign f_end      = {1'b0, 1'b0, r_h} + {1'b0, r_f.size};
    assign b_end      = {1'b0, r_blk} + {1'b0, i_ram_q.size};
    assign g_sum      = {1'b0, r_blk} + {1'b0, r_b.size};

    // next-state logic of the sequencer
    always_comb begin
        n_state     = r_state;
        n_reg       = r_reg;
        n_need      = r_need;
        n_h         = r_h;
        n_blk       = r_blk;
        n_prev      = r_prev;
        n_steps     = r_steps;
        n_aux       = r_aux;
        n_f         = r_f;
        n_b         = r_b;
        n_p         = r_p;
        n_free_head = r_free_head;
        n_left      = r_left;
        n_ready     = r_ready;
        n_res_valid = 1'b0;
        n_res       = r_res;
        req         = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_reg  = i_cmd.region_sel;
                    n_need = need_calc;
                    n_h    = i_cmd.release_unit - 12'd1;
                    unique case (ffra_pkg::t_opcode'(i_cmd.opcode))
                        ffra_pkg::OP_INIT: begin
                            if (!cmd_reg_ok) begin
                                n_res_valid = 1'b1;
                                n_res = '{ffra_pkg::ST_IGNORED, 12'd0, 13'd0};
                            end else if (r_ready[cmd_ri]) begin
                                n_res_valid = 1'b1;
                                n_res = '{ffra_pkg::ST_IGNORED, 12'd0, r_left[cmd_ri]};
                            end else begin
                                n_state = S_INIT_WR;
                            end
                        end
                        ffra_pkg::OP_ALLOC: begin
                            if (!cmd_reg_ok) begin
                                n_res_valid = 1'b1;
                                n_res = '{ffra_pkg::ST_IGNORED, 12'd0, 13'd0};
                            end else begin
                                n_blk   = r_free_head[cmd_ri];
                                n_prev  = NIL;
                                n_steps = '0;
                                n_state = S_A_RD;
                            end
                        end
                        ffra_pkg::OP_FREE: begin
                            if (i_cmd.release_unit == 12'd0) begin
                                n_res_valid = 1'b1;
                                n_res = '{ffra_pkg::ST_IGNORED, 12'd0, 13'd0};
                            end else begin
                                n_state = S_F_RD;
                            end
                        end
                        default: begin
                            n_res_valid = 1'b1;
                            n_res = '{ffra_pkg::ST_IGNORED, 12'd0, 13'd0};
                        end
                    endcase
                end
            end

            // format the region as one free block
            S_INIT_WR: begin
                req.wr_en   = 1'b1;
                req.wr_addr = i_base[r_reg];
                req.wr_data = '{1'b0, r_reg, init_size, NIL};
                n_free_head[cur_ri] = {1'b0, i_base[r_reg]};
                n_left[cur_ri]      = init_size;
                n_ready[cur_ri]     = 1'b1;
                n_res_valid = 1'b1;
                n_res   = '{ffra_pkg::ST_DONE, 12'd0, init_size};
                n_state = S_IDLE;
            end

            // allocate: first-fit walk
            S_A_RD: begin
                if (r_blk < NIL && r_steps < NIL) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = r_blk[AW-1:0];
                    n_state     = S_A_CHK;
                end else begin
                    n_res_valid = 1'b1;
                    n_res   = '{ffra_pkg::ST_NO_FIT, 12'd0, cur_left};
                    n_state = S_IDLE;
                end
            end
            S_A_CHK: begin
                n_b = i_ram_q;
                if (r_need <= i_ram_q.size) begin
                    if (r_need < i_ram_q.size) begin
                        n_b.size = new_size;
                        n_aux    = {1'b0, split_sum[AW-1:0]};
                        n_state  = S_A_SPL1;
                    end else begin
                        n_aux   = i_ram_q.link;
                        n_state = S_A_EX1;
                    end
                end else begin
                    n_prev  = r_blk;
                    n_p     = i_ram_q;
                    n_blk   = i_ram_q.link;
                    n_steps = r_steps + 13'd1;
                    n_state = S_A_RD;
                end
            end
            // split: low part keeps its link, high part becomes the used block
            S_A_SPL1: begin
                req.wr_en   = 1'b1;
                req.wr_addr = r_blk[AW-1:0];
                req.wr_data = r_b;
                n_state     = S_A_SPL2;
            end
            S_A_SPL2: begin
                req.wr_en   = 1'b1;
                req.wr_addr = r_aux[AW-1:0];
                req.wr_data = '{1'b1, r_reg, r_need, NIL};
                n_left[cur_ri] = cur_left - r_need;
                n_res_valid = 1'b1;
                n_res   = '{ffra_pkg::ST_DONE, r_aux[AW-1:0] + 12'd1, cur_left - r_need};
                n_state = S_IDLE;
            end
            // exact fit: unlink, then mark used
            S_A_EX1: begin
                if (r_prev == NIL) begin
                    n_free_head[cur_ri] = r_aux;
                end else begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = r_prev[AW-1:0];
                    req.wr_data = '{r_p.used, r_p.region, r_p.size, r_aux};
                end
                n_state = S_A_EX2;
            end
            S_A_EX2: begin
                req.wr_en   = 1'b1;
                req.wr_addr = r_blk[AW-1:0];
                req.wr_data = '{1'b1, r_reg, r_b.size, NIL};
                n_left[cur_ri] = cur_left - r_need;
                n_res_valid = 1'b1;
                n_res   = '{ffra_pkg::ST_DONE, r_blk[AW-1:0] + 12'd1, cur_left - r_need};
                n_state = S_IDLE;
            end

            // free: fetch and check the released header
            S_F_RD: begin
                req.rd_en   = 1'b1;
                req.rd_addr = r_h;
                n_state     = S_F_CHK;
            end
            S_F_CHK: begin
                n_f = i_ram_q;
                if (!i_ram_q.used || !q_reg_ok || {1'b0, r_h} == q_head) begin
                    n_res_valid = 1'b1;
                    n_res   = '{ffra_pkg::ST_IGNORED, 12'd0, 13'd0};
                    n_state = S_IDLE;
                end else begin
                    n_reg = i_ram_q.region;
                    n_left[q_ri] = r_left[q_ri] + i_ram_q.size;
                    if (q_head >= NIL || {1'b0, r_h} < q_head) begin
                        if (q_head < NIL &&
                            ({1'b0, 1'b0, r_h} + {1'b0, i_ram_q.size}) == {1'b0, q_head}) begin
                            req.rd_en   = 1'b1;
                            req.rd_addr = q_head[AW-1:0];
                            n_state     = S_F_HCHK;
                        end else begin
                            n_state = S_F_TOP;
                        end
                    end else begin
                        n_blk   = q_head;
                        n_prev  = NIL;
                        n_steps = '0;
                        n_state = S_W_RD;
                    end
                end
            end
            // new head, merged with the old head
            S_F_HCHK: begin
                req.wr_en   = 1'b1;
                req.wr_addr = r_h;
                req.wr_data = '{1'b0, r_f.region, r_f.size + i_ram_q.size, i_ram_q.link};
                n_free_head[cur_ri] = {1'b0, r_h};
                n_res_valid = 1'b1;
                n_res   = '{ffra_pkg::ST_DONE, 12'd0, cur_left};
                n_state = S_IDLE;
            end
            // new head in front of the old one, or of an empty list
            S_F_TOP: begin
                req.wr_en   = 1'b1;
                req.wr_addr = r_h;
                req.wr_data = '{1'b0, r_f.region, r_f.size, cur_head};
                n_free_head[cur_ri] = {1'b0, r_h};
                n_res_valid = 1'b1;
                n_res   = '{ffra_pkg::ST_DONE, 12'd0, cur_left};
                n_state = S_IDLE;
            end

            // free: walk to the insertion point
            S_W_RD: begin
                if (r_blk < NIL && {1'b0, r_h} > r_blk && r_steps < NIL) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = r_blk[AW-1:0];
                    n_state     = S_W_CHK;
                end else begin
                    n_state = S_I_LNK;
                end
            end
            S_W_CHK: begin
                n_b = i_ram_q;
                if (b_end == {1'b0, 1'b0, r_h}) begin
                    n_b.size = i_ram_q.size + r_f.size;
                    n_state  = S_W_M1;
                end else begin
                    n_prev  = r_blk;
                    n_p     = i_ram_q;
                    n_blk   = i_ram_q.link;
                    n_steps = r_steps + 13'd1;
                    n_state = S_W_RD;
                end
            end
            // merge into the lower neighbour
            S_W_M1: begin
                req.wr_en   = 1'b1;
                req.wr_addr = r_blk[AW-1:0];
                req.wr_data = r_b;
                n_state     = S_W_M2;
            end
            S_W_M2: begin
                req.wr_en   = 1'b1;
                req.wr_addr = r_h;
                req.wr_data = '{1'b0, r_f.region, r_f.size, r_f.link};
                if (r_b.link < NIL && g_sum == {1'b0, r_b.link}) begin
                    n_aux   = {1'b0, g_sum[AW-1:0]};
                    n_state = S_W_M3;
                end else begin
                    n_res_valid = 1'b1;
                    n_res   = '{ffra_pkg::ST_DONE, 12'd0, cur_left};
                    n_state = S_IDLE;
                end
            end
            S_W_M3: begin
                req.rd_en   = 1'b1;
                req.rd_addr = r_aux[AW-1:0];
                n_state     = S_W_M4;
            end
            // and also absorb the upper neighbour
            S_W_M4: begin
                req.wr_en   = 1'b1;
                req.wr_addr = r_blk[AW-1:0];
                req.wr_data = '{r_b.used, r_b.region, r_b.size + i_ram_q.size, i_ram_q.link};
                n_res_valid = 1'b1;
                n_res   = '{ffra_pkg::ST_DONE, 12'd0, cur_left};
                n_state = S_IDLE;
            end

            // free: link in after the last node visited
            S_I_LNK: begin
                if (r_prev == NIL) begin
                    n_free_head[cur_ri] = {1'b0, r_h};
                end else begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = r_prev[AW-1:0];
                    req.wr_data = '{r_p.used, r_p.region, r_p.size, {1'b0, r_h}};
                end
                n_state = S_I_RD;
            end
            S_I_RD: begin
                if (r_blk < NIL && f_end == {1'b0, r_blk}) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = r_blk[AW-1:0];
                    n_state     = S_I_CHK;
                end else begin
                    req.wr_en   = 1'b1;
                    req.wr_addr = r_h;
                    req.wr_data = '{1'b0, r_f.region, r_f.size, r_blk};
                    n_res_valid = 1'b1;
                    n_res   = '{ffra_pkg::ST_DONE, 12'd0, cur_left};
                    n_state = S_IDLE;
                end
            end
            S_I_CHK: begin
                req.wr_en   = 1'b1;
                req.wr_addr = r_h;
                req.wr_data = '{1'b0, r_f.region, r_f.size + i_ram_q.size, i_ram_q.link};
                n_res_valid = 1'b1;
                n_res   = '{ffra_pkg::ST_DONE, 12'd0, cur_left};
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // keep cached headers coherent with every heap write
        if (req.wr_en) begin
            if (req.wr_addr == r_h) begin
                n_f = req.wr_data;
            end
            if (req.wr_addr == r_blk[AW-1:0]) begin
                n_b = req.wr_data;
            end
            if (req.wr_addr == r_prev[AW-1:0]) begin
                n_p = req.wr_data;
            end
        end
    end

    // state, region bookkeeping and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready     <= '0;
            r_res_valid <= 1'b0;
            for (int i = 0; i < NUM_REGIONS; i++) begin
                r_free_head[i] <= NIL;
                r_left[i]      <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_ready     <= n_ready;
            r_res_valid <= n_res_valid;
            r_free_head <= n_free_head;
            r_left      <= n_left;
        end
        r_reg   <= n_reg;
        r_need  <= n_need;
        r_h     <= n_h;
        r_blk   <= n_blk;
        r_prev  <= n_prev;
        r_steps <= n_steps;
        r_aux   <= n_aux;
        r_f     <= n_f;
        r_b     <= n_b;
        r_p     <= n_p;
        r_res   <= n_res;
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_result    = r_res;
    assign o_ram_req   = req;

endmodule

`default_nettype wire

// ----- hw/rtl/first_fit_region_allocator_top.sv -----
// top level of the first-fit region allocator: configuration, sequencer, heap memory
//
// Usage
//   command channel: drive i_cmd and raise start; the command transfer takes place
//   at a rising edge with start high and busy low. Once high, busy stays high until the result.
//   result channel: o_res_valid is high for exactly one cycle with o_result; the
//   receiver cannot stall it, so it must take the transfer in that cycle.
//   configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx (bases 0..3,
//   then spans 4..7) at the clock edge; write only while busy is low.
// Sequence (from the command transfer to the result)
//   init writes one header; null free, opcode 3 and the other ignored commands give
//   the result directly. allocate reads free-list nodes until one fits or the list
//   ends. free reads the released header, then is ignored, becomes the new head, or
//   walks to its insertion point and merges. One heap read per node, with registered
//   read data, sets the walk rate; a walk stops after HEAP_UNITS nodes.
// Throughput: one command at a time; busy is low in the cycle that shows the
//   result, so the next command transfer can be taken in that cycle.
// Reset
//   synchronous, active low: every region reads as not initialised with an empty
//   list and zero free units; configuration registers clear to zero.
`default_nettype none

module first_fit_region_allocator_top #(
    parameter int NUM_REGIONS = ffra_pkg::NUM_REGIONS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire ffra_pkg::t_cmd    i_cmd,
    output logic                   o_res_valid,
    output ffra_pkg::t_result      o_result,
    input  wire logic              i_cfg_we,
    input  wire logic [2:0]        i_cfg_idx,
    input  wire logic [12:0]       i_cfg_data
);

    logic [11:0] r_base [ffra_pkg::CFG_REGIONS];
    logic [12:0] r_span [ffra_pkg::CFG_REGIONS];
    ffra_pkg::t_ram_req ram_req;
    ffra_pkg::t_hdr     ram_q;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ffra_pkg::CFG_REGIONS; i++) begin
                r_base[i] <= '0;
                r_span[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ffra_pkg::CFG_BASE_ZERO:  r_base[0] <= i_cfg_data[11:0];
                ffra_pkg::CFG_BASE_ONE:   r_base[1] <= i_cfg_data[11:0];
                ffra_pkg::CFG_BASE_TWO:   r_base[2] <= i_cfg_data[11:0];
                ffra_pkg::CFG_BASE_THREE: r_base[3] <= i_cfg_data[11:0];
                ffra_pkg::CFG_SPAN_ZERO:  r_span[0] <= i_cfg_data;
                ffra_pkg::CFG_SPAN_ONE:   r_span[1] <= i_cfg_data;
                ffra_pkg::CFG_SPAN_TWO:   r_span[2] <= i_cfg_data;
                ffra_pkg::CFG_SPAN_THREE: r_span[3] <= i_cfg_data;
            endcase
        end
    end

    // sequencer
    ffra_ctrl #(
        .NUM_REGIONS(NUM_REGIONS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_cmd       (i_cmd),
        .i_base      (r_base),
        .i_span      (r_span),
        .o_res_valid (o_res_valid),
        .o_result    (o_result),
        .o_ram_req   (ram_req),
        .i_ram_q     (ram_q)
    );

    // heap header memory
    ffra_heap_ram u_ram (
        .i_clk (i_clk),
        .i_req (ram_req),
        .o_q   (ram_q)
    );

    // an accepted command either keeps the block busy or has produced its result
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_res_valid)
        else $error("command transfer neither started work nor gave a result");

    // a result only appears once the sequencer is back to idle
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !busy)
        else $error("result shown while busy");

    // only a result with done status returns a nonzero data unit
    a_data_unit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_result.status != ffra_pkg::ST_DONE |-> o_result.data_unit == 12'd0)
        else $error("data unit given with a failing status");

    // status is always a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_result.status == ffra_pkg::ST_DONE ||
                        o_result.status == ffra_pkg::ST_NO_FIT ||
                        o_result.status == ffra_pkg::ST_IGNORED)
        else $error("undefined status code");

endmodule

`default_nettype wire
